// ===== src/box_blur_3x3_rgb_core_assert.svh =====
// Assertion macros shared by the box blur core modules.
`ifndef BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_CORE_ASSERT_SVH

// Same-cycle implication, clocked on aclk and disabled during reset.
`define BBLUR_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and disabled during reset.
`define BBLUR_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/bblur_pkg.sv =====
// Types, constants and the reciprocal table shared by the box blur core.
`default_nettype none

package bblur_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);

    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = 16;
    localparam int IN_ROW_W   = FH_W + 1;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int WIN_N = 9;

    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Entry r*3+c; row 0 is the oldest row, column 2 the newest column.
    typedef logic [WIN_N-1:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
        logic frame_end;
    } mean_ctrl_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } mean_res_t;

    // Rounded-up reciprocal of twice the neighbor count, scaled by 2^RECIP_SHIFT.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        case (count)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/box_blur_3x3_rgb_core.sv =====
// Top level of the streaming 3x3 RGB box blur core.
// The core takes 24-bit RGB pixels in raster order and returns, per pixel, the channel-wise
// mean of its 3x3 neighborhood rounded half up, leaving out neighbors outside the frame.
// Results trail the input by one row and one pixel, so after a frame's pixels the source
// sends drain items (s_func = 1) to release the pending results; m_frame_end marks the last.
// Writing frame_width or frame_height restarts the frame and drops pending results; write
// them only while the core is idle. Each item reads and rewrites one column of two line
// memories whose read data arrive in the cycle after the address. An item passes the read
// and take states, and one that releases a result then waits in the busy state until the
// output register, emptied by m_ready, is free. Memories need no clearing after reset.
`default_nettype none

module box_blur_3x3_rgb_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_func,
    input  wire logic [7:0]                        s_red_in,
    input  wire logic [7:0]                        s_green_in,
    input  wire logic [7:0]                        s_blue_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_red_out,
    output logic [7:0]                             m_green_out,
    output logic [7:0]                             m_blue_out,
    output logic                                   m_frame_end,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "box_blur_3x3_rgb_core_assert.svh"

    typedef enum logic [2:0] {
        S_READ = 3'b001,
        S_TAKE = 3'b010,
        S_BUSY = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [bblur_pkg::FW_W-1:0]          frame_width_reg, frame_width_next;
    logic [bblur_pkg::FH_W-1:0]          frame_height_reg, frame_height_next;
    logic [bblur_pkg::COL_W-1:0]         in_column_reg, in_column_next;
    logic [bblur_pkg::IN_ROW_W-1:0]      in_row_reg, in_row_next;
    logic [bblur_pkg::COL_W-1:0]         out_column_reg, out_column_next;
    logic [bblur_pkg::ROW_W-1:0]         out_row_reg, out_row_next;
    bblur_pkg::window_t                  win_reg, win_next;
    logic                                m_valid_reg, m_valid_next;
    bblur_pkg::mean_res_t                m_res_reg;

    logic [bblur_pkg::WEFF_W-1:0]        w_eff;
    logic [bblur_pkg::FH_W-1:0]          h_eff;
    logic                                input_done;
    logic                                releases;
    logic [bblur_pkg::COL_W-1:0]         col;
    logic [bblur_pkg::WEFF_W-1:0]        col_inc;
    logic [bblur_pkg::PIX_W-1:0]         pix;
    logic                                take_item;
    logic                                proceed;
    logic [bblur_pkg::IN_ROW_W-1:0]      out_row_inc;
    logic [bblur_pkg::WEFF_W-1:0]        out_col_inc;
    logic                                row_last;
    logic                                col_last;
    logic                                frame_last;
    logic [bblur_pkg::PIX_W-1:0]         upper_rdata;
    logic [bblur_pkg::PIX_W-1:0]         middle_rdata;
    logic                                mean_start;
    bblur_pkg::mean_ctrl_t               mean_ctrl;
    bblur_pkg::mean_res_t                mean_res;
    logic                                res_valid;
    logic                                res_ready;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = (bblur_pkg::WEFF_W)'(1);
        end else if (int'(frame_width_reg) > bblur_pkg::MAX_WIDTH) begin
            w_eff = (bblur_pkg::WEFF_W)'(bblur_pkg::MAX_WIDTH);
        end else begin
            w_eff = (bblur_pkg::WEFF_W)'(frame_width_reg);
        end
    end

    assign h_eff      = (frame_height_reg == '0) ? (bblur_pkg::FH_W)'(1) : frame_height_reg;
    assign input_done = in_row_reg >= (bblur_pkg::IN_ROW_W)'(h_eff);
    assign releases   = (in_row_reg >= (bblur_pkg::IN_ROW_W)'(2)) ||
                        ((in_row_reg == (bblur_pkg::IN_ROW_W)'(1)) && (in_column_reg != '0));
    assign col        = ((bblur_pkg::WEFF_W)'(in_column_reg) < w_eff) ? in_column_reg : '0;
    assign col_inc    = (bblur_pkg::WEFF_W)'(col) + (bblur_pkg::WEFF_W)'(1);
    assign pix        = input_done ? '0 : {s_red_in, s_green_in, s_blue_in};

    assign s_ready    = (state_reg == S_TAKE);
    assign take_item  = s_valid && s_ready;
    assign proceed    = take_item && !((s_func == bblur_pkg::FUNC_DRAIN) && !input_done);

    assign out_row_inc = (bblur_pkg::IN_ROW_W)'(out_row_reg) + (bblur_pkg::IN_ROW_W)'(1);
    assign out_col_inc = (bblur_pkg::WEFF_W)'(out_column_reg) + (bblur_pkg::WEFF_W)'(1);
    assign row_last    = out_row_inc >= (bblur_pkg::IN_ROW_W)'(h_eff);
    assign col_last    = out_col_inc >= w_eff;
    assign frame_last  = row_last && col_last;

    assign mean_start          = proceed && releases;
    assign mean_ctrl.up_ok     = (out_row_reg != '0);
    assign mean_ctrl.down_ok   = !row_last;
    assign mean_ctrl.left_ok   = (out_column_reg != '0);
    assign mean_ctrl.right_ok  = !col_last;
    assign mean_ctrl.frame_end = frame_last;

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        win_next = win_reg;
        if (proceed) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r*3]   = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
            win_next[2] = upper_rdata;
            win_next[5] = middle_rdata;
            win_next[8] = pix;
        end
    end

    always_comb begin
        state_next        = state_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_column_next    = in_column_reg;
        in_row_next       = in_row_reg;
        out_column_next   = out_column_reg;
        out_row_next      = out_row_reg;

        case (state_reg)
            S_READ: begin
                state_next = S_TAKE;
            end
            S_TAKE: begin
                if (proceed) begin
                    state_next = releases ? S_BUSY : S_READ;
                end
            end
            S_BUSY: begin
                if (res_valid && res_ready) begin
                    state_next = S_READ;
                end
            end
            default: begin
                state_next = S_READ;
            end
        endcase

        if (proceed) begin
            if (col_inc >= w_eff) begin
                in_column_next = '0;
                in_row_next    = in_row_reg + (bblur_pkg::IN_ROW_W)'(1);
            end else begin
                in_column_next = col_inc[bblur_pkg::COL_W-1:0];
            end
            if (releases) begin
                if (frame_last) begin
                    in_column_next  = '0;
                    in_row_next     = '0;
                    out_column_next = '0;
                    out_row_next    = '0;
                end else if (col_last) begin
                    out_column_next = '0;
                    out_row_next    = out_row_inc[bblur_pkg::ROW_W-1:0];
                end else begin
                    out_column_next = out_col_inc[bblur_pkg::COL_W-1:0];
                end
            end
        end

        // A register write restarts the frame; the column address changes, so reread.
        if (cfg_wr_en) begin
            case (cfg_index)
                bblur_pkg::REG_FRAME_WIDTH: begin
                    frame_width_next = cfg_data[bblur_pkg::FW_W-1:0];
                end
                bblur_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_next = cfg_data[bblur_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
            if (state_reg != S_BUSY) begin
                state_next = S_READ;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_READ;
            frame_width_reg  <= bblur_pkg::FW_RESET;
            frame_height_reg <= bblur_pkg::FH_RESET;
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            out_column_reg   <= '0;
            out_row_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_column_reg    <= in_column_next;
            in_row_reg       <= in_row_next;
            out_column_reg   <= out_column_next;
            out_row_reg      <= out_row_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (res_valid && res_ready) begin
            m_res_reg <= mean_res;
        end
    end

    bblur_ram #(
        .WIDTH (bblur_pkg::PIX_W),
        .DEPTH (bblur_pkg::MAX_WIDTH)
    ) u_upper_ram (
        .aclk  (aclk),
        .we    (proceed),
        .addr  (col),
        .wdata (middle_rdata),
        .rdata (upper_rdata)
    );

    bblur_ram #(
        .WIDTH (bblur_pkg::PIX_W),
        .DEPTH (bblur_pkg::MAX_WIDTH)
    ) u_middle_ram (
        .aclk  (aclk),
        .we    (proceed),
        .addr  (col),
        .wdata (pix),
        .rdata (middle_rdata)
    );

    bblur_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mean_start),
        .ctrl      (mean_ctrl),
        .window    (win_next),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (mean_res)
    );

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_res_reg.red;
    assign m_green_out = m_res_reg.green;
    assign m_blue_out  = m_res_reg.blue;
    assign m_frame_end = m_res_reg.frame_end;

    `BBLUR_ASSERT_IMP(a_in_column_in_row, state_reg == S_TAKE,
        (bblur_pkg::WEFF_W)'(in_column_reg) < w_eff,
        "Input column counter reached the frame width.")

    `BBLUR_ASSERT_IMP(a_out_row_in_frame, 1'b1,
        (bblur_pkg::IN_ROW_W)'(out_row_reg) < (bblur_pkg::IN_ROW_W)'(h_eff),
        "Output row counter reached the frame height.")

    `BBLUR_ASSERT_NXT(a_restart_after_last, proceed && releases && frame_last,
        in_row_reg == '0 && in_column_reg == '0 && out_row_reg == '0 && out_column_reg == '0,
        "Counters did not restart after the last item of a frame.")

endmodule

`default_nettype wire

// ===== src/bblur_ram.sv =====
// Generic single-port RAM with a registered, read-first read.
`default_nettype none

module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bblur_mean.sv =====
// Masked 3x3 sum and reciprocal-multiply rounding divider for three channels.
`default_nettype none

module bblur_mean (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire bblur_pkg::mean_ctrl_t ctrl,
    input  wire bblur_pkg::window_t   window,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output bblur_pkg::mean_res_t      res
);

`include "box_blur_3x3_rgb_core_assert.svh"

    logic [2:0]                                  row_ok;
    logic [2:0]                                  col_ok;
    logic [2:0][2:0][bblur_pkg::SUM_W-1:0]       row_sum;
    logic [2:0][bblur_pkg::NUM_W-1:0]            num_next;
    logic [1:0]                                  rows;
    logic [1:0]                                  cols;
    logic [bblur_pkg::CNT_W-1:0]                 cnt_next;
    logic [bblur_pkg::RECIP_W-1:0]               recip;

    logic                                        sum_vld_reg;
    logic [2:0][bblur_pkg::NUM_W-1:0]            num_reg;
    logic [bblur_pkg::CNT_W-1:0]                 cnt_reg;
    logic                                        fe_a_reg;
    logic                                        prod_vld_reg;
    logic [2:0][bblur_pkg::PROD_W-1:0]           prod_reg;
    logic                                        fe_b_reg;

    assign row_ok = {ctrl.down_ok, 1'b1, ctrl.up_ok};
    assign col_ok = {ctrl.right_ok, 1'b1, ctrl.left_ok};
    assign rows   = 2'd1 + {1'b0, ctrl.up_ok} + {1'b0, ctrl.down_ok};
    assign cols   = 2'd1 + {1'b0, ctrl.left_ok} + {1'b0, ctrl.right_ok};
    assign cnt_next = (bblur_pkg::CNT_W)'(rows) * (bblur_pkg::CNT_W)'(cols);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                row_sum[ch][r] = '0;
                if (row_ok[r]) begin
                    for (int c = 0; c < 3; c++) begin
                        if (col_ok[c]) begin
                            row_sum[ch][r] = row_sum[ch][r] + (bblur_pkg::SUM_W)'(
                                window[r*3+c][(2-ch)*bblur_pkg::CH_W +: bblur_pkg::CH_W]);
                        end
                    end
                end
            end
            num_next[ch] = {row_sum[ch][0] + row_sum[ch][1] + row_sum[ch][2], 1'b0}
                         + (bblur_pkg::NUM_W)'(cnt_next);
        end
    end

    assign recip = bblur_pkg::recip_of(cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            sum_vld_reg <= start;
            if (sum_vld_reg) begin
                prod_vld_reg <= 1'b1;
            end else if (res_ready) begin
                prod_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= num_next;
            cnt_reg  <= cnt_next;
            fe_a_reg <= ctrl.frame_end;
        end
        if (sum_vld_reg) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod_reg[ch] <= (bblur_pkg::PROD_W)'(num_reg[ch]) *
                                (bblur_pkg::PROD_W)'(recip);
            end
            fe_b_reg <= fe_a_reg;
        end
    end

    assign res_valid     = prod_vld_reg;
    assign res.red       = prod_reg[0][bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
    assign res.green     = prod_reg[1][bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
    assign res.blue      = prod_reg[2][bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
    assign res.frame_end = fe_b_reg;

    `BBLUR_ASSERT_IMP(a_start_when_idle, start, !sum_vld_reg && !prod_vld_reg,
        "A new mean started while the previous one was still in flight.")

    `BBLUR_ASSERT_IMP(a_quotient_fits, prod_vld_reg,
        prod_reg[0][30:26] == '0 && prod_reg[1][30:26] == '0 && prod_reg[2][30:26] == '0,
        "A rounded mean exceeded eight bits.")

    `BBLUR_ASSERT_NXT(a_product_follows_sum, sum_vld_reg, prod_vld_reg,
        "A summed mean did not reach the product stage.")

endmodule

`default_nettype wire

// ===== tb/box_blur_3x3_rgb_checker.sv =====
// Checker for the 3x3 RGB box blur core: it predicts each result and compares the output.
`timescale 1ns / 100ps

module box_blur_3x3_rgb_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic                              s_func,
    input  wire logic [7:0]                        s_red_in,
    input  wire logic [7:0]                        s_green_in,
    input  wire logic [7:0]                        s_blue_in,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [7:0]                        m_red_out,
    input  wire logic [7:0]                        m_green_out,
    input  wire logic [7:0]                        m_blue_out,
    input  wire logic                              m_frame_end,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                     fail_count,
    output int                                     waiting_count,
    output int                                     checked_count
);

    logic [bblur_pkg::PIX_W-1:0] upper_line  [bblur_pkg::MAX_WIDTH];
    logic [bblur_pkg::PIX_W-1:0] middle_line [bblur_pkg::MAX_WIDTH];
    logic [bblur_pkg::PIX_W-1:0] win [bblur_pkg::WIN_N];
    int unsigned in_col, in_row, out_col, out_row;
    logic [bblur_pkg::FW_W-1:0] width_reg;
    logic [bblur_pkg::FH_W-1:0] height_reg;
    bblur_pkg::mean_res_t expected_means [$];
    bblur_pkg::mean_res_t want_res;
    bit released;
    int fails = 0;
    int checked = 0;

    function automatic int unsigned eff_width();
        if (width_reg == 0) begin
            return 1;
        end
        if (width_reg > bblur_pkg::MAX_WIDTH) begin
            return bblur_pkg::MAX_WIDTH;
        end
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    task automatic restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic clear_model();
        for (int i = 0; i < bblur_pkg::MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < bblur_pkg::WIN_N; i++) begin
            win[i] = '0;
        end
        restart_frame();
        width_reg = bblur_pkg::FW_RESET;
        height_reg = bblur_pkg::FH_RESET;
    endtask

    // The window column given as centre is the one that holds the output pixel.
    function automatic bblur_pkg::mean_res_t window_mean(input int unsigned centre,
                                                         input int unsigned w,
                                                         input int unsigned h);
        int unsigned sr, sg, sb, n, wc;
        logic [bblur_pkg::PIX_W-1:0] px;
        bblur_pkg::mean_res_t res;
        sr = 0;
        sg = 0;
        sb = 0;
        n = 0;
        res = '0;
        for (int unsigned dr = 0; dr < 3; dr++) begin
            for (int unsigned dc = 0; dc < 3; dc++) begin
                wc = centre + dc - 1;
                if (!(dr == 0 && out_row == 0) && !(dr == 2 && out_row + 1 >= h) &&
                    !(dc == 0 && out_col == 0) && !(dc == 2 && out_col + 1 >= w) &&
                    wc <= 2) begin
                    px = win[dr * 3 + wc];
                    sr += px[23:16];
                    sg += px[15:8];
                    sb += px[7:0];
                    n++;
                end
            end
        end
        if (n != 0) begin
            res.red   = 8'((2 * sr + n) / (2 * n));
            res.green = 8'((2 * sg + n) / (2 * n));
            res.blue  = 8'((2 * sb + n) / (2 * n));
        end
        return res;
    endfunction

    task automatic step_blur(input logic func, input logic [bblur_pkg::PIX_W-1:0] rgb,
                             output bit got, output bblur_pkg::mean_res_t res);
        int unsigned w, h, col;
        logic [bblur_pkg::PIX_W-1:0] pix, above_px, mid_px;
        bit done, rel;
        w = eff_width();
        h = eff_height();
        got = 0;
        res = '0;
        done = in_row >= h;
        if (func == bblur_pkg::FUNC_PIXEL || done) begin
            pix = done ? '0 : rgb;
            rel = in_row >= 2 || (in_row == 1 && in_col >= 1);
            col = (in_col < w) ? in_col : 0;
            if (rel && col == 0) begin
                res = window_mean(2, w, h);
            end
            above_px = upper_line[col];
            mid_px = middle_line[col];
            for (int r = 0; r < 3; r++) begin
                win[r * 3] = win[r * 3 + 1];
                win[r * 3 + 1] = win[r * 3 + 2];
            end
            win[2] = above_px;
            win[5] = mid_px;
            win[8] = pix;
            upper_line[col] = mid_px;
            middle_line[col] = pix;
            if (rel && col != 0) begin
                res = window_mean(1, w, h);
            end
            in_col = col + 1;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (rel) begin
                got = 1;
                if (out_row + 1 >= h && out_col + 1 >= w) begin
                    res.frame_end = 1'b1;
                    restart_frame();
                end else begin
                    res.frame_end = 1'b0;
                    out_col++;
                    if (out_col >= w) begin
                        out_col = 0;
                        out_row++;
                    end
                end
            end
        end
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
            expected_means.delete();
        end else begin
            if (m_valid && m_ready) begin
                checked++;
                if (expected_means.size() == 0) begin
                    $display("%0t: result with nothing pending, actual r=%0d g=%0d b=%0d end=%0b",
                             $time, m_red_out, m_green_out, m_blue_out, m_frame_end);
                    fails++;
                end else begin
                    want_res = expected_means.pop_front();
                    compare_field("red", want_res.red, m_red_out);
                    compare_field("green", want_res.green, m_green_out);
                    compare_field("blue", want_res.blue, m_blue_out);
                    compare_field("frame_end", 8'(want_res.frame_end), 8'(m_frame_end));
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == bblur_pkg::REG_FRAME_WIDTH) begin
                    width_reg = cfg_data[bblur_pkg::FW_W-1:0];
                end else if (cfg_index == bblur_pkg::REG_FRAME_HEIGHT) begin
                    height_reg = cfg_data[bblur_pkg::FH_W-1:0];
                end
                restart_frame();
            end
            if (s_valid && s_ready) begin
                step_blur(s_func, {s_red_in, s_green_in, s_blue_in}, released, want_res);
                if (released) begin
                    expected_means.push_back(want_res);
                end
            end
        end
        fail_count <= fails;
        waiting_count <= expected_means.size();
        checked_count <= checked;
    end

endmodule

// ===== tb/tb_box_blur_3x3_rgb_core.sv =====
// Top of the box blur testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb_core;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RANDOM_ITEMS = 1800;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = bblur_pkg::FUNC_PIXEL;
    logic [7:0] s_red_in = '0;
    logic [7:0] s_green_in = '0;
    logic [7:0] s_blue_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_red_out, m_green_out, m_blue_out;
    logic m_frame_end;
    logic cfg_wr_en = 1'b0;
    logic [bblur_pkg::CFG_IDX_W-1:0] cfg_index = bblur_pkg::REG_FRAME_WIDTH;
    logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count, waiting_count, checked_count;
    int unsigned cycle_count = 0;
    bit tail_phase = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;
    bit sender_gaps = 1'b1;
    int unsigned rx_left = 0;
    int unsigned items_sent = 0;
    int unsigned frames_done = 0;
    int unsigned frames_cut = 0;
    int unsigned cur_w = bblur_pkg::MAX_WIDTH;
    int unsigned cur_h = 1;

    box_blur_3x3_rgb_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .m_frame_end(m_frame_end),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    box_blur_3x3_rgb_checker blur_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .m_frame_end(m_frame_end),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .waiting_count(waiting_count),
        .checked_count(checked_count)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d results still pending",
                     $time, cycle_count, waiting_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The output side stalls in short bursts, runs freely for stretches, and holds off
    // once for a long time so that the core fills up and stalls its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                rx_left = HOLD_CYCLES - 1;
            end else if (rx_left > 0) begin
                rx_left--;
            end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                rx_left = $urandom_range(0, 5);
            end else begin
                m_ready <= 1'b1;
                rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(0, 15);
            end
        end
    end

    function automatic logic [bblur_pkg::PIX_W-1:0] random_pixel(input bit harsh);
        logic [bblur_pkg::PIX_W-1:0] px;
        px = (bblur_pkg::PIX_W)'($urandom);
        if (harsh) begin
            for (int c = 0; c < 3; c++) begin
                case ($urandom_range(0, 5))
                    0: px[c*8 +: 8] = 8'd0;
                    1: px[c*8 +: 8] = 8'd1;
                    2: px[c*8 +: 8] = 8'd127;
                    3: px[c*8 +: 8] = 8'd128;
                    4: px[c*8 +: 8] = 8'd254;
                    default: px[c*8 +: 8] = 8'd255;
                endcase
            end
        end
        return px;
    endfunction

    task automatic send_item(input logic func, input logic [bblur_pkg::PIX_W-1:0] rgb);
        if (sender_gaps && !tail_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        {s_red_in, s_green_in, s_blue_in} <= rgb;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Waits until every predicted result has left the core and the last item has settled.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (waiting_count != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(input logic [bblur_pkg::FW_W-1:0] wd,
                             input logic [bblur_pkg::FH_W-1:0] hd);
        logic [bblur_pkg::CFG_DATA_W-1:0] word;
        word = (bblur_pkg::CFG_DATA_W)'($urandom);
        word[bblur_pkg::FW_W-1:0] = wd;
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= bblur_pkg::REG_FRAME_WIDTH;
        cfg_data <= word;
        @(posedge aclk);
        cfg_index <= bblur_pkg::REG_FRAME_HEIGHT;
        cfg_data <= hd;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_w = (wd == 0) ? 1 : ((wd > bblur_pkg::MAX_WIDTH) ? bblur_pkg::MAX_WIDTH : wd);
        cur_h = (hd == 0) ? 1 : hd;
    endtask

    // Sends n_pix pixels with an occasional early drain; a complete frame is followed by
    // the drain items that flush it, some of them surplus pixels.
    task automatic run_frame(input int unsigned n_pix, input bit complete, input bit harsh);
        for (int unsigned i = 0; i < n_pix; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                send_item(bblur_pkg::FUNC_DRAIN, (bblur_pkg::PIX_W)'($urandom));
            end
            send_item(bblur_pkg::FUNC_PIXEL, random_pixel(harsh));
        end
        if (complete) begin
            for (int unsigned i = 0; i <= cur_w; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(bblur_pkg::FUNC_PIXEL, random_pixel(harsh));
                end else begin
                    send_item(bblur_pkg::FUNC_DRAIN, (bblur_pkg::PIX_W)'($urandom));
                end
            end
            frames_done++;
        end
    endtask

    initial begin
        logic [bblur_pkg::PIX_W-1:0] patterns [9];
        logic [bblur_pkg::FW_W-1:0] w_code;
        logic [bblur_pkg::FH_W-1:0] h_code;
        int unsigned n_pix;
        bit need_cfg;
        patterns = '{24'h000000, 24'hFFFFFF, 24'h55AA0F, 24'hAA55F0, 24'hFF00FF,
                     24'h00FF00, 24'h01807F, 24'hFE7F80, 24'hFFFFFF};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // A drain before any pixel is ignored.
        send_item(bblur_pkg::FUNC_DRAIN, 24'hFFFFFF);

        configure(11'd3, 16'd3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) begin
                send_item(bblur_pkg::FUNC_DRAIN, 24'h123456);
            end
            send_item(bblur_pkg::FUNC_PIXEL, patterns[i]);
        end
        send_item(bblur_pkg::FUNC_DRAIN, 24'h000000);
        send_item(bblur_pkg::FUNC_PIXEL, 24'hFFFFFF);
        send_item(bblur_pkg::FUNC_DRAIN, 24'h000000);
        send_item(bblur_pkg::FUNC_DRAIN, 24'hFFFFFF);
        frames_done++;

        configure(11'd1, 16'd3);
        send_item(bblur_pkg::FUNC_PIXEL, 24'h00FF01);
        send_item(bblur_pkg::FUNC_PIXEL, 24'h01FE00);
        send_item(bblur_pkg::FUNC_PIXEL, 24'hFF00FF);
        send_item(bblur_pkg::FUNC_DRAIN, 24'h000000);
        send_item(bblur_pkg::FUNC_DRAIN, 24'h000000);
        frames_done++;

        // Zero width and zero height both act as one.
        configure(11'd0, 16'd0);
        send_item(bblur_pkg::FUNC_PIXEL, 24'h7F807F);
        send_item(bblur_pkg::FUNC_DRAIN, 24'hFFFFFF);
        send_item(bblur_pkg::FUNC_DRAIN, 24'h000000);
        frames_done++;

        configure(11'd8, 16'd40);
        long_hold_req <= 1'b1;
        run_frame(cur_w * cur_h, 1'b1, 1'b0);

        need_cfg = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: w_code = 11'd1024;
                    1: w_code = 11'd1025;
                    2: w_code = 11'd2047;
                    default: w_code = (bblur_pkg::FW_W)'($urandom);
                endcase
                h_code = ($urandom_range(0, 1) == 0) ? 16'hFFFF : (bblur_pkg::FH_W)'($urandom);
                configure(w_code, h_code);
                n_pix = $urandom_range(1, (cur_w * cur_h < 60) ? cur_w * cur_h : 60);
                run_frame(n_pix, 1'b0, $urandom_range(0, 1));
                frames_cut++;
                need_cfg = 1'b1;
            end else begin
                if (need_cfg || $urandom_range(0, 2) != 0) begin
                    w_code = ($urandom_range(0, 7) == 0)
                           ? (bblur_pkg::FW_W)'($urandom_range(9, 40))
                           : (bblur_pkg::FW_W)'($urandom_range(0, 8));
                    h_code = ($urandom_range(0, 7) == 0)
                           ? (bblur_pkg::FH_W)'($urandom_range(7, 16))
                           : (bblur_pkg::FH_W)'($urandom_range(0, 6));
                    configure(w_code, h_code);
                    need_cfg = 1'b0;
                end
                sender_gaps = $urandom_range(0, 3) != 0;
                run_frame(cur_w * cur_h, 1'b1, $urandom_range(0, 4) == 0);
            end
        end

        sender_gaps = 1'b1;
        tail_phase <= 1'b1;
        repeat (4) begin
            configure((bblur_pkg::FW_W)'($urandom_range(1, 12)),
                      (bblur_pkg::FH_W)'($urandom_range(1, 8)));
            run_frame(cur_w * cur_h, 1'b1, 1'b0);
        end

        s_valid <= 1'b0;
        for (int i = 0; i < 100000 && waiting_count != 0; i++) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        $display("Sent %0d items over %0d complete and %0d cut-short frames; %0d results checked.",
                 items_sent, frames_done, frames_cut, checked_count);
        $display("Widths 0 to 2047 and heights 0 to 65535 were set; output held off %0d cycles once.",
                 HOLD_CYCLES);
        if (fail_count == 0 && waiting_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d expected results never arrived",
                     fail_count, waiting_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
